[rtl/smat_pkg.sv]
package smat_pkg;

  localparam int unsigned Window  = 100;
  localparam int unsigned DataW   = 32;
  localparam int unsigned CountW  = 7;
  localparam int unsigned CntW    = $clog2(Window + 1);
  localparam int unsigned IdxW    = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [DataW-1:0] InitThrReset  = 32'd131072;
  localparam logic [DataW-1:0] FloorThrReset = 32'd13107;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INIT_THR = 1'b0,
    CFG_FLOOR    = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_FLUSH,
    ST_MED_RD,
    ST_DONE
  } win_state_e;

  // Result of one window update, handed to the threshold stage.
  typedef struct packed {
    logic              valid;
    logic [DataW-1:0]  median;
    logic [CntW-1:0]   count;
  } med_t;

endpackage

[rtl/smat_window.sv]
module smat_window (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [smat_pkg::DataW-1:0] error_sample_i,
  output smat_pkg::med_t            med_o,
  input  logic                      thr_ready_i
);
  import smat_pkg::*;

  win_state_e       state_q, state_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [IdxW-1:0]  oldest_q, oldest_d;
  logic [DataW-1:0] sample_q, sample_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic [CntW-1:0]  wr_idx_q, wr_idx_d;
  logic             proc_v_q, proc_v_d;
  logic             drop_pend_q, drop_pend_d;
  logic             ins_pend_q, ins_pend_d;
  logic [DataW-1:0] buf_q, buf_d;
  logic             buf_v_q, buf_v_d;

  logic [DataW-1:0] ring_mem [Window];
  logic [DataW-1:0] ring_rdata_q;
  logic             ring_re, ring_we;
  logic [IdxW-1:0]  ring_waddr;
  logic [DataW-1:0] ring_wdata;

  logic [DataW-1:0] srt_mem [Window];
  logic [DataW-1:0] srt_rdata_q;
  logic             srt_re, srt_we;
  logic [IdxW-1:0]  srt_raddr, srt_waddr;
  logic [DataW-1:0] srt_wdata;

  logic full, acc;

  assign full       = (fill_q == CntW'(Window));
  assign in_stall_o = (state_q != ST_IDLE);
  assign acc        = in_valid_i && (state_q == ST_IDLE);

  assign med_o.valid  = (state_q == ST_DONE);
  assign med_o.median = srt_rdata_q;
  assign med_o.count  = fill_q;

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    if (ring_re) begin
      ring_rdata_q <= ring_mem[oldest_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (srt_we) begin
      srt_mem[srt_waddr] <= srt_wdata;
    end
    if (srt_re) begin
      srt_rdata_q <= srt_mem[srt_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      oldest_q    <= '0;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      proc_v_q    <= 1'b0;
      drop_pend_q <= 1'b0;
      ins_pend_q  <= 1'b0;
      buf_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      oldest_q    <= oldest_d;
      rd_idx_q    <= rd_idx_d;
      wr_idx_q    <= wr_idx_d;
      proc_v_q    <= proc_v_d;
      drop_pend_q <= drop_pend_d;
      ins_pend_q  <= ins_pend_d;
      buf_v_q     <= buf_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    buf_q    <= buf_d;
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    oldest_d    = oldest_q;
    sample_d    = sample_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    proc_v_d    = proc_v_q;
    drop_pend_d = drop_pend_q;
    ins_pend_d  = ins_pend_q;
    buf_d       = buf_q;
    buf_v_d     = buf_v_q;
    ring_re     = 1'b0;
    ring_we     = 1'b0;
    ring_waddr  = oldest_q;
    ring_wdata  = sample_q;
    srt_re      = 1'b0;
    srt_raddr   = rd_idx_q[IdxW-1:0];
    srt_we      = 1'b0;
    srt_waddr   = wr_idx_q[IdxW-1:0];
    srt_wdata   = sample_q;

    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          sample_d    = error_sample_i;
          rd_idx_d    = '0;
          wr_idx_d    = '0;
          proc_v_d    = 1'b0;
          drop_pend_d = full;
          ins_pend_d  = 1'b1;
          buf_v_d     = 1'b0;
          if (full) begin
            ring_re = 1'b1;
            state_d = ST_FETCH;
          end else begin
            ring_we    = 1'b1;
            ring_waddr = fill_q[IdxW-1:0];
            ring_wdata = error_sample_i;
            state_d    = ST_SCAN;
          end
        end
      end

      ST_FETCH: begin
        // The oldest sample is now in ring_rdata_q; overwrite its slot.
        ring_we  = 1'b1;
        oldest_d = (oldest_q == IdxW'(Window - 1)) ? '0 : oldest_q + IdxW'(1);
        state_d  = ST_SCAN;
      end

      ST_SCAN: begin
        if (rd_idx_q < fill_q) begin
          srt_re   = 1'b1;
          rd_idx_d = rd_idx_q + CntW'(1);
          proc_v_d = 1'b1;
        end else begin
          proc_v_d = 1'b0;
        end

        // Merge step: drop the first copy of the old sample and place the
        // new one ahead of the first larger kept entry. At most one write a cycle,
        // with one entry of slack in buf_q.
        if (proc_v_q) begin
          if (drop_pend_q && (srt_rdata_q == ring_rdata_q)) begin
            drop_pend_d = 1'b0;
            if (buf_v_q) begin
              srt_we    = 1'b1;
              srt_wdata = buf_q;
              buf_v_d   = 1'b0;
            end
          end else if (ins_pend_q && (srt_rdata_q > sample_q)) begin
            ins_pend_d = 1'b0;
            srt_we     = 1'b1;
            srt_wdata  = sample_q;
            buf_d      = srt_rdata_q;
            buf_v_d    = 1'b1;
          end else if (buf_v_q) begin
            srt_we    = 1'b1;
            srt_wdata = buf_q;
            buf_d     = srt_rdata_q;
          end else begin
            srt_we    = 1'b1;
            srt_wdata = srt_rdata_q;
          end
          if (srt_we) begin
            wr_idx_d = wr_idx_q + CntW'(1);
          end
        end

        if ((rd_idx_q == fill_q) && !proc_v_q) begin
          state_d = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        if (ins_pend_q) begin
          srt_we    = 1'b1;
          srt_wdata = sample_q;
        end else if (buf_v_q) begin
          srt_we    = 1'b1;
          srt_wdata = buf_q;
        end
        ins_pend_d = 1'b0;
        buf_v_d    = 1'b0;
        if (!full) begin
          fill_d = fill_q + CntW'(1);
        end
        state_d = ST_MED_RD;
      end

      ST_MED_RD: begin
        srt_re    = 1'b1;
        srt_raddr = IdxW'(fill_q >> 1);
        state_d   = ST_DONE;
      end

      ST_DONE: begin
        if (thr_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/smat_thresh.sv]
module smat_thresh (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  smat_pkg::med_t             med_i,
  output logic                       thr_ready_o,
  input  logic [smat_pkg::DataW-1:0] init_thr_i,
  input  logic [smat_pkg::DataW-1:0] floor_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [smat_pkg::DataW-1:0] threshold_o,
  output logic [smat_pkg::CountW-1:0] window_count_o
);
  import smat_pkg::*;

  logic               out_valid_q, out_valid_d;
  logic [DataW-1:0]   thr_q, thr_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [DataW+1:0]   tri_val;
  logic [DataW-1:0]   sat_val;
  logic               take;

  assign thr_ready_o = !out_valid_q || !out_stall_i;
  assign take        = med_i.valid && thr_ready_o;

  // Three times the median as a shift and add, saturated to 32 bits.
  assign tri_val = {2'b00, med_i.median} + {1'b0, med_i.median, 1'b0};
  assign sat_val = (|tri_val[DataW+1:DataW]) ? '1 : tri_val[DataW-1:0];

  always_comb begin
    out_valid_d = out_valid_q;
    thr_d       = thr_q;
    cnt_d       = cnt_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (take) begin
      out_valid_d = 1'b1;
      cnt_d       = CountW'(med_i.count);
      if (med_i.count == '0) begin
        thr_d = init_thr_i;
      end else if (sat_val < floor_i) begin
        thr_d = floor_i;
      end else begin
        thr_d = sat_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    thr_q <= thr_d;
    cnt_q <= cnt_d;
  end

  assign out_valid_o    = out_valid_q;
  assign threshold_o    = thr_q;
  assign window_count_o = cnt_q;

endmodule

[rtl/sliding_median_adaptive_threshold_top.sv]
// An accepted item runs through the states fetch (only into a full window of 100, to fetch
// the oldest sample from the ring), scan, flush, median read and done. The block takes no
// new item until the last one has left the done state. The scan is the merge pass that
// walks the sorted window one entry per cycle through its read port.
// Reset clears the fill count, ring pointer and handshake state, loads the threshold defaults.
module sliding_median_adaptive_threshold_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [smat_pkg::DataW-1:0]  error_sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [smat_pkg::DataW-1:0]  threshold_o,
  output logic [smat_pkg::CountW-1:0] window_count_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [smat_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [smat_pkg::DataW-1:0]  cfg_data_i
);
  import smat_pkg::*;

  logic [DataW-1:0] init_thr_q, init_thr_d;
  logic [DataW-1:0] floor_q, floor_d;
  med_t             med;
  logic             thr_ready;

  // The register file takes a write in every cycle.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    init_thr_d = init_thr_q;
    floor_d    = floor_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_INIT_THR: init_thr_d = cfg_data_i;
        CFG_FLOOR:    floor_d    = cfg_data_i;
        default:      init_thr_d = init_thr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_thr_q <= InitThrReset;
      floor_q    <= FloorThrReset;
    end else begin
      init_thr_q <= init_thr_d;
      floor_q    <= floor_d;
    end
  end

  // The window keeps the samples in arrival order and in sorted order. Each item
  // runs one merge pass over the sorted memory: once the window is full the oldest
  // sample is dropped, the new one is slotted in, and the median is read back at the end.
  smat_window u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .error_sample_i (error_sample_i),
    .med_o          (med),
    .thr_ready_i    (thr_ready)
  );

  // Three times the median, saturated and held at the floor, goes to the output
  // register. It frees the window as soon as the previous item has been taken.
  smat_thresh u_thresh (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .med_i          (med),
    .thr_ready_o    (thr_ready),
    .init_thr_i     (init_thr_q),
    .floor_i        (floor_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .threshold_o    (threshold_o),
    .window_count_o (window_count_o)
  );

  // An accepted item keeps the window busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("window took an item and was not busy afterwards");

  // While a finished update waits for the output register, no item is taken.
  a_stall_while_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    med.valid |-> in_stall_o)
    else $error("input open while a window result is pending");

  // A handed-off update shows up as a valid item at the output next cycle.
  a_handoff_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (med.valid && thr_ready) |=> out_valid_o)
    else $error("window result lost on the way to the output register");

  // Every delivered item reports a non-empty window no larger than its depth.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((window_count_o != '0) && (CntW'(window_count_o) <= CntW'(Window))))
    else $error("window count out of range");

endmodule

[sim/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import smat_pkg::*;

  typedef logic [DataW-1:0] word_t;

  // One expected result: the threshold for the next frame and the window fill.
  typedef struct packed {
    logic [DataW-1:0]  threshold;
    logic [CountW-1:0] count;
  } thr_result_t;

  // The run holds about 1715 items. With stalls on both sides and the long
  // hold-off, a correct run stays far below this limit.
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned IdlePct    = 19;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [DataW-1:0]    error_sample_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [DataW-1:0]    threshold_o;
  logic [CountW-1:0]   window_count_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [DataW-1:0]    cfg_data_i;

  sliding_median_adaptive_threshold_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .error_sample_i (error_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .threshold_o    (threshold_o),
    .window_count_o (window_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Shadow copy of the block's state. The window is kept twice: once in
  // arrival order, so that the oldest sample is known, and once in ascending
  // order, so that the median is a single lookup.
  word_t       arrival_q[$];
  word_t       sorted_q[$];
  word_t       init_thr_reg;
  word_t       floor_reg;
  thr_result_t threshold_q[$];

  int unsigned err_count;
  int unsigned cycle_cnt;
  thr_result_t want;

  // Random idling on both sides is switched off for one long stretch.
  bit          gaps_on;
  bit          stalls_on;
  bit          hold_start;
  int unsigned hold_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung block must still end the run with a verdict.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Works out the result of one accepted sample. When the window is full the
  // oldest sample goes first; any one of several equal entries may be dropped
  // from the sorted copy, since they are the same value. The median is the
  // upper one, at index count/2, and three times it saturates to all ones.
  function automatic void predict_threshold(word_t smp);
    word_t       old_v;
    int          pos;
    logic [33:0] triple;
    word_t       thr;
    thr_result_t r;
    if (arrival_q.size() == Window) begin
      old_v = arrival_q.pop_front();
      pos = 0;
      while (sorted_q[pos] != old_v) pos++;
      sorted_q.delete(pos);
    end
    arrival_q = {arrival_q, smp};
    pos = 0;
    while (pos < sorted_q.size() && sorted_q[pos] <= smp) pos++;
    sorted_q.insert(pos, smp);
    triple = {2'b00, sorted_q[sorted_q.size() / 2]} * 34'd3;
    thr = (triple > 34'h0_FFFF_FFFF) ? '1 : triple[DataW-1:0];
    if (thr < floor_reg) thr = floor_reg;
    r.threshold = thr;
    r.count     = CountW'(sorted_q.size());
    threshold_q = {threshold_q, r};
  endfunction

  // Draws one sample. The mix leans on the interesting regions: small values
  // where the floor wins, the border of saturation around 0x55555555, a small
  // pool of repeated values so that equal samples enter and leave the window,
  // and the two extremes. zero_pct biases the stream toward zeros so that the
  // median itself can become zero.
  function automatic word_t pick_sample(int unsigned zero_pct);
    if ($urandom_range(0, 99) < zero_pct) return '0;
    case ($urandom_range(0, 7))
      0, 1: return $urandom();
      2: return $urandom_range(0, 32'h0000_FFFF);
      3: return $urandom_range(0, 32'h000A_0000);
      4: return 32'h5555_5555 + $urandom_range(0, 64) - 32'd32;
      5: return word_t'($urandom_range(0, 3)) << 16;
      6: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return $urandom_range(32'h0001_0000, 32'h0004_0000);
    endcase
  endfunction

  // Offers one item and waits for the block to take it. Valid stays high on
  // return, so back-to-back items keep it high without a glitch; gaps are
  // opened at the start of the next call instead.
  task automatic send_sample(input word_t smp);
    while (gaps_on && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    error_sample_i <= smp;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    predict_threshold(smp);
    @(negedge clk_i);
  endtask

  task automatic send_burst(input int unsigned n, input int unsigned zero_pct);
    repeat (n) send_sample(pick_sample(zero_pct));
  endtask

  // Drops valid and waits until every expected result has come out, plus a
  // short margin so the block is back in its idle state.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (threshold_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // Register write, only ever issued while the block is idle. The extra
  // falling edge at the end keeps a following write from raising valid in the
  // same step in which this one lowers it.
  task automatic write_reg(input cfg_idx_e idx, input word_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    case (idx)
      CFG_INIT_THR: init_thr_reg = val;
      CFG_FLOOR:    floor_reg    = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Reset defaults: floor wins for tiny medians, the floor is matched
  // exactly (3 * 4369 = 13107), and the saturation border is walked from
  // 0x55555555 (exactly all ones, no clipping) to 0x55555556 (clipped).
  task automatic test_directed_edges();
    word_t vals[$];
    vals = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'd4369, 32'd4370, 32'd4370,
             32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 32'h5555_5556,
             32'h5555_5556, 32'h5555_5556, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'h0001_0000};
    foreach (vals[i]) send_sample(vals[i]);
    wait_drained();
  endtask

  // Register extremes. A floor of all ones pins every threshold to all ones;
  // a floor of zero leaves three times the median unchanged. The initial
  // threshold is written at both ends too, although it never reaches the
  // output once a sample has been seen.
  task automatic test_config_extremes();
    write_reg(CFG_INIT_THR, '0);
    write_reg(CFG_FLOOR, '1);
    repeat (5) send_sample(pick_sample(0));
    wait_drained();
    write_reg(CFG_FLOOR, '0);
    write_reg(CFG_INIT_THR, '1);
    repeat (5) send_sample(32'h0);
    wait_drained();
  endtask

  // Long random stream in several register settings. The window fills to
  // 100 early on and then slides for the rest of the run, so the wrap of the
  // oldest-sample pointer is crossed many times.
  task automatic test_random_stream();
    word_t init_v;
    // Software's usual setting: floor is one tenth of the initial value.
    init_v = $urandom_range(32'h0000_8000, 32'h0010_0000);
    write_reg(CFG_INIT_THR, init_v);
    write_reg(CFG_FLOOR, init_v / 10);
    send_burst(400, 5);
    wait_drained();

    // A stretch with no idling on either side at all.
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_burst(250, 5);
    wait_drained();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    // Floor off and mostly zeros: the median drops to zero, then recovers.
    write_reg(CFG_FLOOR, '0);
    send_burst(300, 70);
    wait_drained();

    // Floor in the range of typical medians, so both sides of the max win.
    write_reg(CFG_FLOOR, $urandom_range(0, 32'h001E_0000));
    write_reg(CFG_INIT_THR, $urandom());
    send_burst(300, 10);
    wait_drained();

    // Back to the reset values for the last part.
    write_reg(CFG_INIT_THR, InitThrReset);
    write_reg(CFG_FLOOR, FloorThrReset);
    send_burst(400, 5);
    wait_drained();
  endtask

  // The receiver holds off for a long time while items keep coming, so the
  // result path fills and the block has to stall its input.
  task automatic test_backpressure();
    gaps_on    = 1'b0;
    hold_start = 1'b1;
    @(negedge clk_i);
    @(negedge clk_i);
    send_burst(40, 5);
    gaps_on = 1'b1;
    wait_drained();
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_stall_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_start) begin
        hold_left  = HoldCycles;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= stalls_on && ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  // Result checker: every item leaving the block is matched against the
  // oldest expectation, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (threshold_q.size() == 0) begin
        $error("unexpected result: threshold %h window_count %0d",
               threshold_o, window_count_o);
        err_count++;
      end else begin
        want = threshold_q.pop_front();
        if (threshold_o !== want.threshold) begin
          $error("threshold: expected %h, got %h", want.threshold, threshold_o);
          err_count++;
        end
        if (window_count_o !== want.count) begin
          $error("window_count: expected %0d, got %0d", want.count, window_count_o);
          err_count++;
        end
      end
    end
  end

  // Main sequence: reset once, then the tests in turn, then the verdict.
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    error_sample_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_INIT_THR;
    cfg_data_i     = '0;
    err_count      = 0;
    cycle_cnt      = 0;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    hold_start     = 1'b0;
    init_thr_reg   = InitThrReset;
    floor_reg      = FloorThrReset;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_edges();
    test_config_extremes();
    test_random_stream();
    test_backpressure();

    wait_drained();
    repeat (150) @(negedge clk_i);
    if (err_count == 0 && threshold_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
